FILE: hdl/sbr_pkg.sv
// shared types and constants for the secs-i block receiver
`timescale 1ns / 1ps

package sbr_pkg;

    // link phases
    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_BLOCK  = 2'd1,
        PH_ERROR  = 2'd2,
        PH_LENGTH = 2'd3
    } t_phase;

    // item function codes
    localparam logic [1:0] FN_BYTE    = 2'd0;
    localparam logic [1:0] FN_TICK    = 2'd1;
    localparam logic [1:0] FN_RESTART = 2'd2;

    // control characters
    localparam logic [7:0] CH_ENQ = 8'h05;
    localparam logic [7:0] CH_EOT = 8'h04;
    localparam logic [7:0] CH_ACK = 8'h06;
    localparam logic [7:0] CH_NAK = 8'h15;

    // reported link state
    localparam logic [1:0] LS_IDLE  = 2'd0;
    localparam logic [1:0] LS_RECV  = 2'd1;
    localparam logic [1:0] LS_ERROR = 2'd2;

    // error causes
    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_TIMEOUT  = 2'd1;
    localparam logic [1:0] ERR_CHECKSUM = 2'd2;

    // configuration register indexes
    localparam int                   CFG_IDX_W       = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_TIMEOUT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_RETRY   = 1'b1;
    localparam int                   CFG_DATA_W      = 16;

    // reset values of the configuration registers
    localparam logic [15:0] RST_TIMEOUT = 16'd1000;
    localparam logic [7:0]  RST_RETRY   = 8'd3;

    // header bytes kept after the length byte
    localparam int HDR_DEPTH = 10;
    localparam int HDR_IDX_W = 4;

    typedef struct packed {
        logic        send_valid;
        logic [7:0]  send_byte;
        logic [1:0]  link_state;
        logic [1:0]  error_code;
        logic        message_ok;
        logic [6:0]  stream;
        logic [7:0]  function_code;
        logic [31:0] system_bytes;
        logic        reply_bit;
        logic        wait_bit;
        logic        end_bit;
    } t_result;

endpackage

FILE: hdl/sbr_core.sv
// link state, checksum and header capture for one item per step
`timescale 1ns / 1ps

module sbr_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic [1:0]       i_func,
    input  logic [7:0]       i_rx_byte,
    input  logic [15:0]      i_timeout,
    input  logic [7:0]       i_retry_limit,
    output sbr_pkg::t_result o_result
);

    sbr_pkg::t_phase r_phase, n_phase;
    logic [7:0]  r_bytes_seen, n_bytes_seen;
    logic [7:0]  r_block_length, n_block_length;
    logic [15:0] r_running_sum, n_running_sum;
    logic [7:0]  r_recv_hi, n_recv_hi;
    logic [7:0]  r_retries, n_retries;
    logic [15:0] r_timer, n_timer;
    logic [1:0]  r_err, n_err;
    logic [7:0]  r_header [sbr_pkg::HDR_DEPTH];
    logic [7:0]  n_header [sbr_pkg::HDR_DEPTH];

    logic        is_byte, is_tick, is_restart;
    logic        hdr_we, last_byte, sum_match, expire;
    logic [15:0] timer_dec;

    assign is_byte    = i_step && (i_func == sbr_pkg::FN_BYTE);
    assign is_tick    = i_step && (i_func == sbr_pkg::FN_TICK);
    assign is_restart = i_step && (i_func == sbr_pkg::FN_RESTART);

    // checksum low byte arrives one past the high byte
    assign last_byte = ({1'b0, r_bytes_seen} == ({1'b0, r_block_length} + 9'd1));
    assign sum_match = (r_running_sum == {r_recv_hi, i_rx_byte});
    assign hdr_we    = is_byte && (r_phase == sbr_pkg::PH_BLOCK)
                    && (r_bytes_seen < 8'(sbr_pkg::HDR_DEPTH));
    assign timer_dec = (r_timer != 16'd0) ? (r_timer - 16'd1) : 16'd0;
    assign expire    = (timer_dec == 16'd0);

    // next state
    always_comb begin
        n_phase        = r_phase;
        n_bytes_seen   = r_bytes_seen;
        n_block_length = r_block_length;
        n_running_sum  = r_running_sum;
        n_recv_hi      = r_recv_hi;
        n_retries      = r_retries;
        n_timer        = r_timer;
        n_err          = r_err;
        for (int i = 0; i < sbr_pkg::HDR_DEPTH; i++) begin
            n_header[i] = (hdr_we && (r_bytes_seen[sbr_pkg::HDR_IDX_W-1:0]
                          == sbr_pkg::HDR_IDX_W'(i))) ? i_rx_byte : r_header[i];
        end
        case (r_phase)
            sbr_pkg::PH_IDLE: begin
                if (is_byte && (i_rx_byte == sbr_pkg::CH_ENQ)) begin
                    n_phase = sbr_pkg::PH_LENGTH;
                    n_timer = i_timeout;
                    n_err   = sbr_pkg::ERR_NONE;
                end
            end
            sbr_pkg::PH_LENGTH, sbr_pkg::PH_BLOCK: begin
                if (is_byte && (r_phase == sbr_pkg::PH_LENGTH)) begin
                    n_block_length = i_rx_byte;
                    n_running_sum  = 16'd0;
                    n_bytes_seen   = 8'd0;
                    n_phase        = sbr_pkg::PH_BLOCK;
                end else if (is_byte) begin
                    if (r_bytes_seen < r_block_length) begin
                        n_running_sum = r_running_sum + {8'd0, i_rx_byte};
                    end
                    if (r_bytes_seen == r_block_length) begin
                        n_recv_hi = i_rx_byte;
                    end
                    if (last_byte) begin
                        if (sum_match) begin
                            n_phase = sbr_pkg::PH_IDLE;
                        end else begin
                            n_phase   = sbr_pkg::PH_ERROR;
                            n_err     = sbr_pkg::ERR_CHECKSUM;
                            n_retries = i_retry_limit;
                        end
                    end else if (r_bytes_seen != 8'hff) begin
                        n_bytes_seen = r_bytes_seen + 8'd1;
                    end
                end else if (is_tick) begin
                    n_timer = timer_dec;
                    if (expire) begin
                        if (r_retries == 8'd0) begin
                            n_phase   = sbr_pkg::PH_ERROR;
                            n_err     = sbr_pkg::ERR_TIMEOUT;
                            n_retries = i_retry_limit;
                        end else begin
                            n_retries = r_retries - 8'd1;
                            n_phase   = sbr_pkg::PH_IDLE;
                        end
                    end
                end
            end
            sbr_pkg::PH_ERROR: begin
                if (is_restart) begin
                    n_phase = sbr_pkg::PH_IDLE;
                    n_err   = sbr_pkg::ERR_NONE;
                end
            end
            default: begin
                n_phase = r_phase;
            end
        endcase
    end

    // result of the current item
    always_comb begin
        o_result            = '0;
        o_result.send_valid = 1'b0;
        o_result.send_byte  = 8'd0;
        o_result.message_ok = 1'b0;
        case (r_phase)
            sbr_pkg::PH_IDLE: begin
                if (is_byte && (i_rx_byte == sbr_pkg::CH_ENQ)) begin
                    o_result.send_valid = 1'b1;
                    o_result.send_byte  = sbr_pkg::CH_EOT;
                end
            end
            sbr_pkg::PH_LENGTH, sbr_pkg::PH_BLOCK: begin
                if (is_byte && (r_phase == sbr_pkg::PH_BLOCK) && last_byte) begin
                    o_result.send_valid = 1'b1;
                    o_result.send_byte  = sum_match ? sbr_pkg::CH_ACK : sbr_pkg::CH_NAK;
                    o_result.message_ok = sum_match;
                end else if (is_tick && expire && (r_retries == 8'd0)) begin
                    o_result.send_valid = 1'b1;
                    o_result.send_byte  = sbr_pkg::CH_NAK;
                end
            end
            default: begin
                o_result.send_valid = 1'b0;
            end
        endcase
        case (n_phase)
            sbr_pkg::PH_IDLE:  o_result.link_state = sbr_pkg::LS_IDLE;
            sbr_pkg::PH_ERROR: o_result.link_state = sbr_pkg::LS_ERROR;
            default:           o_result.link_state = sbr_pkg::LS_RECV;
        endcase
        o_result.error_code = (n_phase == sbr_pkg::PH_ERROR) ? n_err : sbr_pkg::ERR_NONE;
        if (o_result.message_ok) begin
            o_result.stream        = n_header[2][6:0];
            o_result.wait_bit      = n_header[2][7];
            o_result.function_code = n_header[3];
            o_result.reply_bit     = n_header[0][7];
            o_result.end_bit       = n_header[4][7];
            o_result.system_bytes  = {n_header[6], n_header[7], n_header[8], n_header[9]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= sbr_pkg::PH_IDLE;
            r_bytes_seen   <= 8'd0;
            r_block_length <= 8'd0;
            r_running_sum  <= 16'd0;
            r_recv_hi      <= 8'd0;
            r_retries      <= sbr_pkg::RST_RETRY;
            r_timer        <= 16'd0;
            r_err          <= sbr_pkg::ERR_NONE;
        end else begin
            r_phase        <= n_phase;
            r_bytes_seen   <= n_bytes_seen;
            r_block_length <= n_block_length;
            r_running_sum  <= n_running_sum;
            r_recv_hi      <= n_recv_hi;
            r_retries      <= n_retries;
            r_timer        <= n_timer;
            r_err          <= n_err;
        end
    end

    // header store keeps the first bytes after the length byte; on a short block these include the checksum
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < sbr_pkg::HDR_DEPTH; i++) begin
            r_header[i] <= n_header[i];
        end
    end

endmodule

FILE: hdl/secs_block_receiver.sv
// SECS-I block receiver top level
// Input channel: i_in_valid / o_in_stall carry one item (i_func, i_rx_byte):
//   a received byte, a timer tick or a restart from the error state.
// Output channel: o_out_valid / i_out_stall carry exactly one result item per
//   input item: the control byte to transmit (EOT, ACK or NAK), the link state,
//   the held error cause and, on the item that completes a good block, the
//   stream, function, system bytes and the R, W and E header bits.
// Pipeline: an accepted item waits in the input register, is processed by the
//   core from there and its result is registered in the output register. One
//   item per cycle is sustained while the receiver does not stall; the only loop
//   is the link state update of the core.
// Configuration: i_cfg_we writes i_cfg_data into the register named by
//   i_cfg_index (0 reply timeout in ticks, 1 retry limit); write only while
//   no item is in flight.
// Reset (i_rst_n low, synchronous): link idle, both registers empty, timeout
//   1000 ticks, retry limit 3 and retry count 3.
// When the receiver stalls the result is held in the output register and the
//   next item waits in the input register; o_in_stall rises only while both
//   are occupied.
`timescale 1ns / 1ps

module secs_block_receiver (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [1:0]                     i_func,
    input  logic [7:0]                     i_rx_byte,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic                           o_send_valid,
    output logic [7:0]                     o_send_byte,
    output logic [1:0]                     o_link_state,
    output logic [1:0]                     o_error_code,
    output logic                           o_message_ok,
    output logic [6:0]                     o_stream,
    output logic [7:0]                     o_function_code,
    output logic [31:0]                    o_system_bytes,
    output logic                           o_reply_bit,
    output logic                           o_wait_bit,
    output logic                           o_end_bit,
    input  logic                           i_cfg_we,
    input  logic [sbr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [sbr_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    logic [15:0] r_timeout;
    logic [7:0]  r_retry_limit;
    logic        r_in_valid;
    logic [1:0]  r_in_func;
    logic [7:0]  r_in_byte;
    logic        r_out_valid;
    sbr_pkg::t_result r_out;
    sbr_pkg::t_result core_result;

    logic advance, load;

    // the input register moves on whenever the output register is free
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign load       = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout     <= sbr_pkg::RST_TIMEOUT;
            r_retry_limit <= sbr_pkg::RST_RETRY;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                sbr_pkg::CFG_IDX_TIMEOUT: r_timeout     <= i_cfg_data[15:0];
                sbr_pkg::CFG_IDX_RETRY:   r_retry_limit <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_in_func <= i_func;
            r_in_byte <= i_rx_byte;
        end
        if (advance) begin
            r_out <= core_result;
        end
    end

    sbr_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (advance),
        .i_func        (r_in_func),
        .i_rx_byte     (r_in_byte),
        .i_timeout     (r_timeout),
        .i_retry_limit (r_retry_limit),
        .o_result      (core_result)
    );

    assign o_out_valid     = r_out_valid;
    assign o_send_valid    = r_out.send_valid;
    assign o_send_byte     = r_out.send_byte;
    assign o_link_state    = r_out.link_state;
    assign o_error_code    = r_out.error_code;
    assign o_message_ok    = r_out.message_ok;
    assign o_stream        = r_out.stream;
    assign o_function_code = r_out.function_code;
    assign o_system_bytes  = r_out.system_bytes;
    assign o_reply_bit     = r_out.reply_bit;
    assign o_wait_bit      = r_out.wait_bit;
    assign o_end_bit       = r_out.end_bit;

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid && i_out_stall))
        else $error("input stalled without a held item");

    a_item_reaches_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !(r_out_valid && i_out_stall)) |=> o_out_valid)
        else $error("processed item did not reach the output register");

    a_ok_sends_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_message_ok) |->
        (o_send_valid && (o_send_byte == sbr_pkg::CH_ACK)
         && (o_link_state == sbr_pkg::LS_IDLE)))
        else $error("accepted block without ack");

    a_error_code_only_in_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_link_state != sbr_pkg::LS_ERROR)) |->
        (o_error_code == sbr_pkg::ERR_NONE))
        else $error("error code outside the error state");

endmodule

FILE: tb/secs_block_receiver_tb.sv
// self-checking testbench for the secs-i block receiver: directed and random link traffic
`timescale 1ns / 1ps

module secs_block_receiver_tb;

    localparam int          CYCLE_LIMIT = 500000;
    localparam int          IDLE_PCT    = 27;
    localparam int          PHASE_ITEMS = 20;
    localparam logic [1:0]  FN_UNUSED   = 2'd3;
    localparam logic [15:0] TICK_SETTLE = 16'd300;

    typedef enum {BLK_MORE, BLK_GOOD, BLK_BAD} t_blk_verdict;

    class link_checker;
        logic [15:0]      timeout_ticks;
        logic [7:0]       retry_limit;
        sbr_pkg::t_phase  phase;
        logic [7:0]       bytes_seen;
        logic [7:0]       block_len;
        logic [15:0]      run_sum;
        logic [15:0]      rx_sum;
        logic [7:0]       hdr [sbr_pkg::HDR_DEPTH];
        logic [7:0]       retries_left;
        logic [15:0]      timer_left;
        logic [1:0]       held_err;
        sbr_pkg::t_result expected_status_q [$];
        int unsigned      mismatches;

        function new();
            timeout_ticks = sbr_pkg::RST_TIMEOUT;
            retry_limit   = sbr_pkg::RST_RETRY;
            phase         = sbr_pkg::PH_IDLE;
            bytes_seen    = '0;
            block_len     = '0;
            run_sum       = '0;
            rx_sum        = '0;
            foreach (hdr[i]) hdr[i] = '0;
            retries_left  = sbr_pkg::RST_RETRY;
            timer_left    = '0;
            held_err      = sbr_pkg::ERR_NONE;
            mismatches    = 0;
        endfunction

        function void write_reg(logic [sbr_pkg::CFG_IDX_W-1:0] idx, logic [15:0] data);
            if (idx == sbr_pkg::CFG_IDX_TIMEOUT) begin
                timeout_ticks = data;
            end else if (idx == sbr_pkg::CFG_IDX_RETRY) begin
                retry_limit = data[7:0];
            end
        endfunction

        function void enter_error(logic [1:0] cause);
            phase        = sbr_pkg::PH_ERROR;
            held_err     = cause;
            retries_left = retry_limit;
        endfunction

        // one byte inside a block; the index sticks at 255 on a maximum-length block
        function t_blk_verdict take_block_byte(logic [7:0] b);
            int k;
            int len;
            k   = int'(bytes_seen);
            len = int'(block_len);
            if (k < sbr_pkg::HDR_DEPTH) hdr[bytes_seen[sbr_pkg::HDR_IDX_W-1:0]] = b;
            if (k < len) run_sum = run_sum + {8'h00, b};
            if (k == len) rx_sum = {b, 8'h00};
            if (k == len + 1) begin
                rx_sum[7:0] = b;
                if (run_sum == rx_sum) begin
                    return BLK_GOOD;
                end else begin
                    return BLK_BAD;
                end
            end
            if (bytes_seen != 8'hFF) bytes_seen++;
            return BLK_MORE;
        endfunction

        function void note_rx_item(logic [1:0] f, logic [7:0] b);
            sbr_pkg::t_result want;
            t_blk_verdict     verdict;
            want = '0;
            case (f)
                sbr_pkg::FN_BYTE: begin
                    case (phase)
                        sbr_pkg::PH_IDLE: begin
                            if (b == sbr_pkg::CH_ENQ) begin
                                want.send_valid = 1'b1;
                                want.send_byte  = sbr_pkg::CH_EOT;
                                timer_left      = timeout_ticks;
                                held_err        = sbr_pkg::ERR_NONE;
                                phase           = sbr_pkg::PH_LENGTH;
                            end
                        end
                        sbr_pkg::PH_LENGTH: begin
                            block_len  = b;
                            run_sum    = '0;
                            bytes_seen = '0;
                            phase      = sbr_pkg::PH_BLOCK;
                        end
                        sbr_pkg::PH_BLOCK: begin
                            verdict = take_block_byte(b);
                            if (verdict == BLK_GOOD) begin
                                want.send_valid = 1'b1;
                                want.send_byte  = sbr_pkg::CH_ACK;
                                want.message_ok = 1'b1;
                                phase           = sbr_pkg::PH_IDLE;
                            end else if (verdict == BLK_BAD) begin
                                want.send_valid = 1'b1;
                                want.send_byte  = sbr_pkg::CH_NAK;
                                enter_error(sbr_pkg::ERR_CHECKSUM);
                            end
                        end
                        default: ;
                    endcase
                end
                sbr_pkg::FN_TICK: begin
                    if (phase == sbr_pkg::PH_BLOCK || phase == sbr_pkg::PH_LENGTH) begin
                        if (timer_left != 0) timer_left--;
                        if (timer_left == 0) begin
                            if (retries_left == 0) begin
                                want.send_valid = 1'b1;
                                want.send_byte  = sbr_pkg::CH_NAK;
                                enter_error(sbr_pkg::ERR_TIMEOUT);
                            end else begin
                                retries_left--;
                                phase = sbr_pkg::PH_IDLE;
                            end
                        end
                    end
                end
                sbr_pkg::FN_RESTART: begin
                    if (phase == sbr_pkg::PH_ERROR) begin
                        phase    = sbr_pkg::PH_IDLE;
                        held_err = sbr_pkg::ERR_NONE;
                    end
                end
                default: ;
            endcase
            case (phase)
                sbr_pkg::PH_ERROR: begin
                    want.link_state = sbr_pkg::LS_ERROR;
                    want.error_code = held_err;
                end
                sbr_pkg::PH_IDLE: want.link_state = sbr_pkg::LS_IDLE;
                default: want.link_state = sbr_pkg::LS_RECV;
            endcase
            if (want.message_ok) begin
                want.stream        = hdr[2][6:0];
                want.function_code = hdr[3];
                want.system_bytes  = {hdr[6], hdr[7], hdr[8], hdr[9]};
                want.reply_bit     = hdr[0][7];
                want.wait_bit      = hdr[2][7];
                want.end_bit       = hdr[4][7];
            end
            expected_status_q.push_back(want);
        endfunction

        function void compare_field(string fname, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $display("%0t: %s expected %0h, got %0h", $time, fname, want, got);
                mismatches++;
            end
        endfunction

        function void check_status(sbr_pkg::t_result got);
            sbr_pkg::t_result want;
            if (expected_status_q.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                mismatches++;
                return;
            end
            want = expected_status_q.pop_front();
            compare_field("send_valid", 32'(want.send_valid), 32'(got.send_valid));
            compare_field("send_byte", 32'(want.send_byte), 32'(got.send_byte));
            compare_field("link_state", 32'(want.link_state), 32'(got.link_state));
            compare_field("error_code", 32'(want.error_code), 32'(got.error_code));
            compare_field("message_ok", 32'(want.message_ok), 32'(got.message_ok));
            compare_field("stream", 32'(want.stream), 32'(got.stream));
            compare_field("function_code", 32'(want.function_code),
                          32'(got.function_code));
            compare_field("system_bytes", want.system_bytes, got.system_bytes);
            compare_field("reply_bit", 32'(want.reply_bit), 32'(got.reply_bit));
            compare_field("wait_bit", 32'(want.wait_bit), 32'(got.wait_bit));
            compare_field("end_bit", 32'(want.end_bit), 32'(got.end_bit));
        endfunction
    endclass

    logic                           i_clk;
    logic                           i_rst_n     = 1'b0;
    logic                           i_in_valid  = 1'b0;
    logic                           o_in_stall;
    logic [1:0]                     i_func      = sbr_pkg::FN_BYTE;
    logic [7:0]                     i_rx_byte   = 8'h00;
    logic                           o_out_valid;
    logic                           i_out_stall = 1'b0;
    logic                           o_send_valid;
    logic [7:0]                     o_send_byte;
    logic [1:0]                     o_link_state;
    logic [1:0]                     o_error_code;
    logic                           o_message_ok;
    logic [6:0]                     o_stream;
    logic [7:0]                     o_function_code;
    logic [31:0]                    o_system_bytes;
    logic                           o_reply_bit;
    logic                           o_wait_bit;
    logic                           o_end_bit;
    logic                           i_cfg_we    = 1'b0;
    logic [sbr_pkg::CFG_IDX_W-1:0]  i_cfg_index = sbr_pkg::CFG_IDX_TIMEOUT;
    logic [sbr_pkg::CFG_DATA_W-1:0] i_cfg_data  = '0;

    link_checker sb;
    bit          idle_on     = 1'b1;
    int unsigned phase_items = 0;
    int unsigned cycle_count = 0;

    secs_block_receiver u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_func          (i_func),
        .i_rx_byte       (i_rx_byte),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_send_valid    (o_send_valid),
        .o_send_byte     (o_send_byte),
        .o_link_state    (o_link_state),
        .o_error_code    (o_error_code),
        .o_message_ok    (o_message_ok),
        .o_stream        (o_stream),
        .o_function_code (o_function_code),
        .o_system_bytes  (o_system_bytes),
        .o_reply_bit     (o_reply_bit),
        .o_wait_bit      (o_wait_bit),
        .o_end_bit       (o_end_bit),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        i_out_stall <= idle_on && ($urandom_range(99) < IDLE_PCT);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
            sb.check_status({o_send_valid, o_send_byte, o_link_state, o_error_code,
                             o_message_ok, o_stream, o_function_code, o_system_bytes,
                             o_reply_bit, o_wait_bit, o_end_bit});
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // valid stays high between back-to-back items, dropped only for a gap
    task automatic send_item(input logic [1:0] f, input logic [7:0] b, input bit counted);
        while (idle_on && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_func     <= f;
        i_rx_byte  <= b;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_rx_item(f, b);
        if (counted) phase_items++;
    endtask

    task automatic drain_link();
        i_in_valid <= 1'b0;
        while (sb.expected_status_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_config(input logic [15:0] tmo, input logic [7:0] rl);
        drain_link();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= sbr_pkg::CFG_IDX_TIMEOUT;
        i_cfg_data  <= tmo;
        @(posedge i_clk);
        sb.write_reg(sbr_pkg::CFG_IDX_TIMEOUT, tmo);
        i_cfg_index <= sbr_pkg::CFG_IDX_RETRY;
        i_cfg_data  <= {8'h00, rl};
        @(posedge i_clk);
        sb.write_reg(sbr_pkg::CFG_IDX_RETRY, {8'h00, rl});
        i_cfg_we <= 1'b0;
    endtask

    // bring the link back to idle: restart an error, else tick or byte it out
    task automatic settle_link();
        while (sb.phase != sbr_pkg::PH_IDLE) begin
            if (sb.phase == sbr_pkg::PH_ERROR) begin
                send_item(sbr_pkg::FN_RESTART, 8'($urandom), 1'b0);
            end else if (sb.timeout_ticks <= TICK_SETTLE ||
                         (sb.phase == sbr_pkg::PH_BLOCK && sb.block_len == 8'hFF)) begin
                send_item(sbr_pkg::FN_TICK, 8'($urandom), 1'b0);
            end else if (sb.phase == sbr_pkg::PH_LENGTH) begin
                send_item(sbr_pkg::FN_BYTE, 8'($urandom_range(8)), 1'b0);
            end else begin
                send_item(sbr_pkg::FN_BYTE, 8'($urandom), 1'b0);
            end
        end
    endtask

    // fill below zero gives random data bytes
    task automatic send_block(input int len, input bit corrupt, input int fill);
        logic [15:0] sum;
        logic [7:0]  b;
        sum = '0;
        settle_link();
        send_item(sbr_pkg::FN_BYTE, sbr_pkg::CH_ENQ, 1'b1);
        send_item(sbr_pkg::FN_BYTE, 8'(len), 1'b1);
        for (int i = 0; i < len; i++) begin
            b = (fill < 0) ? 8'($urandom) : 8'(fill);
            if ($urandom_range(99) < 5) send_item(sbr_pkg::FN_TICK, 8'($urandom), 1'b1);
            send_item(sbr_pkg::FN_BYTE, b, 1'b1);
            sum = sum + {8'h00, b};
        end
        if (corrupt) sum = sum ^ 16'($urandom_range(1, 65535));
        send_item(sbr_pkg::FN_BYTE, sum[15:8], 1'b1);
        send_item(sbr_pkg::FN_BYTE, sum[7:0], 1'b1);
    endtask

    task automatic send_timeout_run();
        settle_link();
        send_item(sbr_pkg::FN_BYTE, sbr_pkg::CH_ENQ, 1'b1);
        if ($urandom_range(1)) begin
            send_item(sbr_pkg::FN_BYTE, 8'($urandom_range(20, 254)), 1'b1);
            repeat ($urandom_range(3)) send_item(sbr_pkg::FN_BYTE, 8'($urandom), 1'b1);
        end
        while (sb.phase == sbr_pkg::PH_LENGTH || sb.phase == sbr_pkg::PH_BLOCK) begin
            send_item(sbr_pkg::FN_TICK, 8'($urandom), 1'b1);
        end
    endtask

    // maximum length: the index saturates and only the reply timer ends it
    task automatic send_longest_block();
        settle_link();
        send_item(sbr_pkg::FN_BYTE, sbr_pkg::CH_ENQ, 1'b1);
        send_item(sbr_pkg::FN_BYTE, 8'hFF, 1'b1);
        repeat (258) send_item(sbr_pkg::FN_BYTE, 8'($urandom), 1'b1);
        while (sb.phase == sbr_pkg::PH_BLOCK) send_item(sbr_pkg::FN_TICK, 8'($urandom), 1'b1);
    endtask

    task automatic send_noise();
        repeat ($urandom_range(1, 6)) send_item(2'($urandom), 8'($urandom), 1'b0);
    endtask

    task automatic run_random_phase(input logic [15:0] tmo, input logic [7:0] rl,
                                    input bit idling, input bit noisy, input bit longest);
        int pick;
        int len;
        write_config(tmo, rl);
        idle_on     = idling;
        phase_items = 0;
        if (longest) send_longest_block();
        while (phase_items < PHASE_ITEMS) begin
            pick = $urandom_range(99);
            len  = ($urandom_range(9) == 0) ? $urandom_range(60) : $urandom_range(16);
            if (pick < 55) begin
                send_block(len, 1'b0, -1);
            end else if (pick < 68) begin
                send_block(len, 1'b1, -1);
            end else if (pick < 82 && tmo <= TICK_SETTLE) begin
                send_timeout_run();
            end else if (noisy) begin
                send_noise();
            end else begin
                send_block(len, 1'b0, -1);
            end
        end
        settle_link();
    endtask

    initial begin
        sb = new();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // the first block fills the whole header store before anything is accepted
        send_block(10, 1'b0, 8'hFF);
        send_item(sbr_pkg::FN_BYTE, 8'h00, 1'b1);
        send_item(FN_UNUSED, 8'hA5, 1'b1);
        send_item(sbr_pkg::FN_RESTART, 8'h00, 1'b1);
        send_block(0, 1'b0, 8'h00);
        // enq inside a block, then a bad checksum and an enq byte while the error is held
        send_block(1, 1'b1, sbr_pkg::CH_ENQ);
        send_item(sbr_pkg::FN_BYTE, sbr_pkg::CH_ENQ, 1'b1);
        send_item(sbr_pkg::FN_RESTART, 8'hFF, 1'b1);

        run_random_phase(16'd20, 8'd2, 1'b1, 1'b1, 1'b1);
        run_random_phase(16'd0, 8'd0, 1'b1, 1'b1, 1'b0);
        run_random_phase(16'd1, 8'd255, 1'b0, 1'b1, 1'b0);
        run_random_phase(16'd65535, 8'd1, 1'b1, 1'b0, 1'b0);
        run_random_phase(16'd6, 8'd3, 1'b1, 1'b1, 1'b0);

        drain_link();
        repeat (4) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.expected_status_q.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

FILE: sim.f
hdl/sbr_pkg.sv
hdl/sbr_core.sv
hdl/secs_block_receiver.sv
tb/secs_block_receiver_tb.sv
